### src/oes_pkg.sv
// Package for the open element stack: field widths, opcodes, FSM states
// and the structs passed between the core and its stack cells.
// No dependencies.
package oes_pkg;

	// Fixed field widths of the command and response channels.
	localparam int OPCODE_W  = 4;
	localparam int ELEM_W    = 16;
	localparam int TAG_W     = 8;
	localparam int IDX_W     = 6;
	localparam int POS_OUT_W = 6;
	localparam int DEPTH_W   = 7;

	// Default stack size and the number of cells between chain registers.
	localparam int NUM_ENTRIES_DEF = 64;
	localparam int SEG_CELLS       = 32;

	// Operation codes carried in the opcode field.
	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH           = 4'd0,
		OP_POP            = 4'd1,
		OP_PEEK           = 4'd2,
		OP_READ           = 4'd3,
		OP_CONTAINS       = 4'd4,
		OP_FIND           = 4'd5,
		OP_POP_TO_ELEMENT = 4'd6,
		OP_POP_TO_TAG     = 4'd7,
		OP_CLEAR          = 4'd8
	} op_e_t;

	// Core control states.
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Search request broadcast to every cell.
	typedef struct packed {
		logic              match_tag;
		logic              match_handle;
		logic              match_top;
		logic              match_index;
		logic [ELEM_W-1:0] handle;
		logic [TAG_W-1:0]  tag;
		logic [IDX_W-1:0]  index;
	} query_t;

	// Search result handed from cell to cell, top of stack toward bottom.
	typedef struct packed {
		logic              found;
		logic [ELEM_W-1:0] handle;
	} link_t;

endpackage

### src/oes_channels.sv
// Valid/ready channel interfaces for the open element stack.
// Depends on oes_pkg for field widths.
interface oes_cmd_if import oes_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [ELEM_W-1:0]   element_id;
	logic [TAG_W-1:0]    tag_id;
	logic [IDX_W-1:0]    index;

	modport source (output valid, opcode, element_id, tag_id, index, input ready);
	modport sink   (input valid, opcode, element_id, tag_id, index, output ready);
endinterface

interface oes_rsp_if import oes_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 ok;
	logic [ELEM_W-1:0]    element_out;
	logic [POS_OUT_W-1:0] position_out;
	logic [DEPTH_W-1:0]   depth_out;
	logic                 overflow;

	modport source (output valid, ok, element_out, position_out, depth_out, overflow,
		input ready);
	modport sink   (input valid, ok, element_out, position_out, depth_out, overflow,
		output ready);
endinterface

### src/oes_cell.sv
// One stack cell: holds the entry at a fixed position, compares it against
// the broadcast query and passes the top-most hit down the chain.
// Depends on oes_pkg.
module oes_cell import oes_pkg::*; #(
	parameter int POSITION = 0,
	parameter int POS_W    = 6,
	parameter int CNT_W    = 7,
	parameter bit REG_OUT  = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  query_t            query,
	input  logic [CNT_W-1:0]  count,
	input  logic              wr_en,
	input  link_t             link_in,
	input  logic [POS_W-1:0]  pos_in,
	output link_t             link_out,
	output logic [POS_W-1:0]  pos_out
);

	logic [ELEM_W-1:0] handle_q;
	logic [TAG_W-1:0]  tag_q;
	logic              in_use;
	logic              is_top;
	logic              is_index;
	logic              hit;
	link_t             link_nxt;
	logic [POS_W-1:0]  pos_nxt;

	// Entry storage, written by a push that lands on this position.
	always_ff @(posedge clk) begin
		if (wr_en && count == CNT_W'(POSITION)) begin
			handle_q <= query.handle;
			tag_q    <= query.tag;
		end
	end

	// Per-cell compare against the query.
	always_comb begin
		in_use   = CNT_W'(POSITION) < count;
		is_top   = CNT_W'(POSITION + 1) == count;
		is_index = {{POS_W{1'b0}}, query.index} == (POS_W + IDX_W)'(POSITION);
		hit      = in_use && ((query.match_tag && tag_q == query.tag)
			|| (query.match_handle && handle_q == query.handle)
			|| (query.match_top && is_top)
			|| (query.match_index && is_index));
	end

	// A hit from above wins; otherwise this cell offers its own entry.
	always_comb begin
		if (link_in.found) begin
			link_nxt = link_in;
			pos_nxt  = pos_in;
		end else begin
			link_nxt.found  = hit;
			link_nxt.handle = handle_q;
			pos_nxt         = POS_W'(POSITION);
		end
	end

	// Cells at a segment boundary register what they hand on.
	if (REG_OUT) begin : g_reg
		logic              found_q;
		logic [ELEM_W-1:0] link_handle_q;
		logic [POS_W-1:0]  pos_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				found_q <= 1'b0;
			end else begin
				found_q <= link_nxt.found;
			end
		end

		always_ff @(posedge clk) begin
			link_handle_q <= link_nxt.handle;
			pos_q         <= pos_nxt;
		end

		assign link_out = '{found: found_q, handle: link_handle_q};
		assign pos_out  = pos_q;
	end else begin : g_comb
		assign link_out = link_nxt;
		assign pos_out  = pos_nxt;
	end

endmodule

### src/open_element_stack_with_tag_search_core.sv
// Top level of the open element stack with tag search: command decode,
// control FSM, the chain of stack cells and the response register.
// Depends on oes_pkg, oes_channels and oes_cell.
//
//  channel | dir | payload                                              | handshake
//  --------+-----+------------------------------------------------------+------------
//  cmd     | in  | opcode, element_id, tag_id, index                    | valid/ready
//  rsp     | out | ok, element_out, position_out, depth_out, overflow   | valid/ready
//
// Every command is captured on acceptance, scanned while the search result
// ripples from the top cell down, with one chain register for every 32 cells,
// and then committed to the response register.
// One command is in flight at a time; cmd.ready is high whenever the FSM idles.
// A response waiting on rsp.ready holds the finished command in the scan state.
// Reset clears the depth, the FSM and the response valid; entries need no reset.
module open_element_stack_with_tag_search_core import oes_pkg::*; #(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	oes_cmd_if.sink   cmd,
	oes_rsp_if.source rsp
);

	localparam int POS_W = $clog2(NUM_ENTRIES);
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
	localparam int NREG  = (NUM_ENTRIES - 1) / SEG_CELLS;
	localparam int SCW   = $clog2(NREG + 2);

	state_t              state_q;
	state_t              state_nxt;
	logic [SCW-1:0]      scan_cnt_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_nxt;
	op_e_t               op_q;
	logic [ELEM_W-1:0]   elem_q;
	logic [TAG_W-1:0]    tag_q;
	logic [IDX_W-1:0]    idx_q;
	logic                accept;
	logic                scan_done;
	logic                commit;
	logic                push_we;
	query_t              query;
	link_t               link_out [NUM_ENTRIES];
	logic [POS_W-1:0]    pos_out  [NUM_ENTRIES];
	logic                ok_nxt;
	logic [ELEM_W-1:0]   eout_nxt;
	logic [POS_W-1:0]    pos_nxt;
	logic                ovf_nxt;
	logic                rsp_valid_q;
	logic                ok_q;
	logic [ELEM_W-1:0]   eout_q;
	logic [POS_W-1:0]    pos_q;
	logic                ovf_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (commit) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// FSM outputs.
	always_comb begin
		cmd.ready = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: cmd.ready = 1'b1;
			ST_SCAN: commit = scan_done && (!rsp_valid_q || rsp.ready);
			default: begin
				cmd.ready = 1'b0;
				commit    = 1'b0;
			end
		endcase
	end

	assign accept    = cmd.valid && cmd.ready;
	assign scan_done = scan_cnt_q == SCW'(NREG);

	// State, scan counter and stack depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
			count_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				scan_cnt_q <= '0;
			end else if (state_q == ST_SCAN && !scan_done) begin
				scan_cnt_q <= scan_cnt_q + SCW'(1);
			end
			if (commit) count_q <= count_nxt;
		end
	end

	// Command capture; held for the whole scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_e_t'(cmd.opcode);
			elem_q <= cmd.element_id;
			tag_q  <= cmd.tag_id;
			idx_q  <= cmd.index;
		end
	end

	// Query broadcast to the cells; null keys never search.
	always_comb begin
		query.match_tag    = (op_q inside {OP_CONTAINS, OP_FIND, OP_POP_TO_TAG})
			&& tag_q != '0;
		query.match_handle = op_q == OP_POP_TO_ELEMENT && elem_q != '0;
		query.match_top    = op_q inside {OP_POP, OP_PEEK};
		query.match_index  = op_q == OP_READ;
		query.handle       = elem_q;
		query.tag          = tag_q;
		query.index        = idx_q;
	end

	assign push_we = commit && op_q == OP_PUSH && elem_q != '0
		&& count_q != CNT_W'(NUM_ENTRIES);

	// Chain of cells, top position feeding downward.
	for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
		link_t            link_in;
		logic [POS_W-1:0] pos_in;

		if (i == NUM_ENTRIES - 1) begin : g_head
			assign link_in = '0;
			assign pos_in  = '0;
		end else begin : g_link
			assign link_in = link_out[i+1];
			assign pos_in  = pos_out[i+1];
		end

		oes_cell #(
			.POSITION (i),
			.POS_W    (POS_W),
			.CNT_W    (CNT_W),
			.REG_OUT  ((i % SEG_CELLS) == 0 && i != 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.query    (query),
			.count    (count_q),
			.wr_en    (push_we),
			.link_in  (link_in),
			.pos_in   (pos_in),
			.link_out (link_out[i]),
			.pos_out  (pos_out[i])
		);
	end

	// Result and new depth from the bottom of the chain.
	always_comb begin
		ok_nxt    = 1'b0;
		eout_nxt  = '0;
		pos_nxt   = '0;
		ovf_nxt   = 1'b0;
		count_nxt = count_q;
		case (op_q)
			OP_PUSH: begin
				ok_nxt = push_we;
				if (elem_q != '0 && count_q == CNT_W'(NUM_ENTRIES)) ovf_nxt = 1'b1;
				if (push_we) count_nxt = count_q + CNT_W'(1);
			end
			OP_POP: begin
				if (link_out[0].found) begin
					ok_nxt    = 1'b1;
					eout_nxt  = link_out[0].handle;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_PEEK, OP_READ: begin
				if (link_out[0].found) begin
					ok_nxt   = 1'b1;
					eout_nxt = link_out[0].handle;
				end
			end
			OP_CONTAINS: ok_nxt = link_out[0].found;
			OP_FIND: begin
				if (link_out[0].found) begin
					ok_nxt  = 1'b1;
					pos_nxt = pos_out[0];
				end
			end
			OP_POP_TO_ELEMENT, OP_POP_TO_TAG: begin
				if (query.match_handle || query.match_tag) begin
					if (link_out[0].found) begin
						ok_nxt    = 1'b1;
						eout_nxt  = link_out[0].handle;
						count_nxt = CNT_W'(pos_out[0]);
					end else begin
						count_nxt = '0;
					end
				end
			end
			OP_CLEAR: begin
				ok_nxt    = 1'b1;
				count_nxt = '0;
			end
			default: ok_nxt = 1'b0;
		endcase
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			ok_q   <= ok_nxt;
			eout_q <= eout_nxt;
			pos_q  <= pos_nxt;
			ovf_q  <= ovf_nxt;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = ok_q;
	assign rsp.element_out  = eout_q;
	assign rsp.position_out = POS_OUT_W'(pos_q);
	assign rsp.depth_out    = DEPTH_W'(count_q);
	assign rsp.overflow     = ovf_q;

endmodule

### src/oes_checker.sv
// Port-level checker for the open element stack core, bound to the top level.
// Depends on oes_pkg and open_element_stack_with_tag_search_core.
module oes_checker import oes_pkg::*; #(
	parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic                 rsp_ok,
	input logic [ELEM_W-1:0]    rsp_element_out,
	input logic [DEPTH_W-1:0]   rsp_depth_out,
	input logic                 rsp_overflow
);

	// A pending response stays offered until taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response withdrawn before transaction completed");

	// Only one command is in flight: acceptance drops ready next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while another is in flight");

	// A dropped push reports a full stack and no success.
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_overflow |-> !rsp_ok && rsp_element_out == '0
			&& rsp_depth_out == DEPTH_W'(NUM_ENTRIES))
		else $error("overflow flagged with inconsistent response");

	// Reported depth never exceeds the stack size; checked for stacks of up to 64 entries.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> NUM_ENTRIES > 64 || int'(rsp_depth_out) <= NUM_ENTRIES)
		else $error("reported depth beyond stack size");

endmodule

bind open_element_stack_with_tag_search_core oes_checker #(
	.NUM_ENTRIES (NUM_ENTRIES)
) u_oes_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_ok          (rsp.ok),
	.rsp_element_out (rsp.element_out),
	.rsp_depth_out   (rsp.depth_out),
	.rsp_overflow    (rsp.overflow)
);
